FILE: hw/rtl/tsrs_pkg.sv
// Package for the TDMA slot role scheduler: item types, role codes and lookup tables.
`default_nettype none

package tsrs_pkg;

   // Frame length in slots, 12 to 256
   localparam int FRAME_SLOTS = 48;

   localparam int CYCLE_SLOTS = 12;
   localparam int HALF_SLOTS  = 6;

   // Role codes
   localparam logic [1:0] ROLE_RF       = 2'd0;
   localparam logic [1:0] ROLE_PAGING   = 2'd1;
   localparam logic [1:0] ROLE_RESPONSE = 2'd2;
   localparam logic [1:0] ROLE_UNUSED   = 2'd3;

   // Divide by nine: floor(id * DIV9_RECIP / 2^DIV9_SHIFT) is exact for 16-bit ids
   localparam logic [16:0] DIV9_RECIP = 17'd58255;
   localparam int          DIV9_SHIFT = 19;

   typedef struct packed {
      logic [7:0]  current_slot;
      logic [15:0] station_id;
   } req_type;

   typedef struct packed {
      logic [1:0] slot_role;
      logic [7:0] beacon_slot;
   } rsp_type;

   typedef logic [255:0][7:0] base_table_type;
   typedef logic [255:0][3:0] pos_table_type;

   // (12 * q) mod FRAME_SLOTS for every 8-bit q
   function automatic base_table_type build_base_table();
      base_table_type tbl;
      logic [8:0]     acc;
      acc = 9'd0;
      for (int i = 0; i < 256; i++) begin
         tbl[i] = acc[7:0];
         acc = acc + 9'(CYCLE_SLOTS);
         if (acc >= 9'(FRAME_SLOTS)) begin
            acc = acc - 9'(FRAME_SLOTS);
         end
      end
      return tbl;
   endfunction

   // Position 1..12 within the 12-slot cycle for every 8-bit slot number
   function automatic pos_table_type build_pos_table();
      pos_table_type tbl;
      logic [3:0]    acc;
      acc = 4'(CYCLE_SLOTS);
      for (int i = 0; i < 256; i++) begin
         tbl[i] = acc;
         acc = (acc == 4'(CYCLE_SLOTS)) ? 4'd1 : acc + 4'd1;
      end
      return tbl;
   endfunction

   localparam base_table_type BEACON_BASE = build_base_table();
   localparam pos_table_type  SLOT_POS    = build_pos_table();

endpackage

`default_nettype wire

FILE: hw/rtl/tsrs_beacon.sv
// Beacon slot of a station: id mod 9 and id / 9 by reciprocal, then reduced to the frame.
`default_nettype none

module tsrs_beacon (
   input  wire logic [15:0] station_id,
   output logic [7:0]       beacon_slot
);
   import tsrs_pkg::*;

   logic [32:0] prod;
   logic [12:0] quot;
   logic [16:0] rem_wide;
   logic [3:0]  rem;
   logic [3:0]  b;
   logic [7:0]  q8;
   logic [8:0]  sum;

   // Quotient and remainder by nine
   assign prod     = 33'(station_id) * 33'(DIV9_RECIP);
   assign quot     = prod[DIV9_SHIFT +: 13];
   assign rem_wide = 17'(station_id) - 17'(quot) * 17'd9;
   assign rem      = rem_wide[3:0];

   // Offset within the cycle: zero maps to ten, then five and up move by one
   always_comb begin
      if (rem == 4'd0) begin
         b = 4'd10;
      end else if (rem >= 4'd5) begin
         b = rem + 4'd1;
      end else begin
         b = rem;
      end
   end

   // Cycle number, one less when the offset wrapped past the cycle end
   assign q8 = (b == 4'd10 && quot[7:0] != 8'd0) ? quot[7:0] - 8'd1 : quot[7:0];

   // Base is already below the frame length; the offset is below it too
   assign sum = 9'(BEACON_BASE[q8]) + 9'(b);
   assign beacon_slot = (sum >= 9'(FRAME_SLOTS)) ? 8'(sum - 9'(FRAME_SLOTS)) : sum[7:0];

endmodule

`default_nettype wire

FILE: hw/rtl/tsrs_role.sv
// Slot role decision and the two force flags of the paging and response halves.
`default_nettype none

module tsrs_role (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire tsrs_pkg::req_type item,
   input  wire logic [7:0]       beacon_slot,
   output logic [1:0]            slot_role
);
   import tsrs_pkg::*;

   logic       paging_forced_ff, paging_forced_in;
   logic       response_forced_ff, response_forced_in;
   logic [3:0] pos;
   logic       paging_half;
   logic [2:0] half_pos;
   logic       flag;
   logic       hit;
   logic       forced_grant;
   logic       grant;
   logic       collide_set;

   // Position within the half
   assign pos         = SLOT_POS[item.current_slot];
   assign paging_half = (pos <= 4'(HALF_SLOTS));
   assign half_pos    = paging_half ? pos[2:0] : 3'(pos - 4'(HALF_SLOTS));
   assign flag        = paging_half ? paging_forced_ff : response_forced_ff;

   // Match, forced grant at the last position, collision with the beacon
   assign hit = (half_pos == 3'd5 && item.station_id[1:0] == 2'd0) ||
                (half_pos == {1'b0, item.station_id[1:0]});
   assign forced_grant = (half_pos == 3'(HALF_SLOTS)) && flag;
   assign collide_set  = !forced_grant && hit && (item.current_slot == beacon_slot);
   assign grant        = forced_grant || (hit && item.current_slot != beacon_slot);

   assign slot_role = !grant ? ROLE_RF : (paging_half ? ROLE_PAGING : ROLE_RESPONSE);

   // Flag updates: collision sets own half, grant clears the other half
   always_comb begin
      paging_forced_in   = paging_forced_ff;
      response_forced_in = response_forced_ff;
      if (paging_half) begin
         if (collide_set) paging_forced_in = 1'b1;
         if (grant) response_forced_in = 1'b0;
      end else begin
         if (collide_set) response_forced_in = 1'b1;
         if (grant) paging_forced_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         paging_forced_ff   <= 1'b0;
         response_forced_ff <= 1'b0;
      end else if (load) begin
         paging_forced_ff   <= paging_forced_in;
         response_forced_ff <= response_forced_in;
      end
   end

   // A paging grant leaves the response flag clear
   a_paging_clears: assert property (@(posedge clock) disable iff (reset)
      load && slot_role == ROLE_PAGING |=> !response_forced_ff)
      else $error("paging grant did not clear response flag");

   // A response grant leaves the paging flag clear
   a_response_clears: assert property (@(posedge clock) disable iff (reset)
      load && slot_role == ROLE_RESPONSE |=> !paging_forced_ff)
      else $error("response grant did not clear paging flag");

   // A cancelled match never grants and always arms its half
   a_collision: assert property (@(posedge clock) disable iff (reset)
      load && collide_set |-> slot_role == ROLE_RF ##1
      (paging_forced_ff || response_forced_ff))
      else $error("beacon collision handled wrongly");

endmodule

`default_nettype wire

FILE: hw/rtl/tdma_slot_role_scheduler_unit.sv
// Top level of the TDMA slot role scheduler: input register, decision logic, result register.
// The block takes one slot tick per cycle unless rsp_ready stalls it and returns one result
// per tick, in order: slot role (RF, paging request, response) and the station's beacon slot
// within the frame. An accepted tick moves from the input register to the result register,
// which drives rsp_valid, once the result side is free; the sustained rate is one item per
// clock when not stalled, set by the single pass between the two registers, where one 17 by
// 16 bit multiplier divides the station id by nine. Ticks are decided in acceptance order, so
// the force flags always reflect every earlier tick. No clearing pass follows reset.
`default_nettype none

module tdma_slot_role_scheduler_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tsrs_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tsrs_pkg::rsp_type      rsp_payload
);
   import tsrs_pkg::*;

   logic       in_valid_ff;
   req_type    in_item_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_item_ff;
   logic       out_free;
   logic       advance;
   logic [7:0] beacon_slot;
   logic [1:0] slot_role;

   // Handshake: the input stage moves whenever the result register is free
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   tsrs_beacon u_beacon (
      .station_id  (in_item_ff.station_id),
      .beacon_slot (beacon_slot)
   );

   tsrs_role u_role (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .item        (in_item_ff),
      .beacon_slot (beacon_slot),
      .slot_role   (slot_role)
   );

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (out_free) rsp_valid_ff <= in_valid_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_item_ff <= req_payload;
      if (advance) begin
         rsp_item_ff.slot_role   <= slot_role;
         rsp_item_ff.beacon_slot <= beacon_slot;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

   // Role code is always one of the three roles
   a_role_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.slot_role != ROLE_UNUSED)
      else $error("unused role code on output");

   // Beacon slot lies within the frame
   a_beacon_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 9'(rsp_payload.beacon_slot) < 9'(FRAME_SLOTS))
      else $error("beacon slot beyond frame");

   // An item leaving the input stage lands in the result register
   a_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("item lost between stages");

endmodule

`default_nettype wire
